>>> sv/ebt_pkg.sv
// Shared types for the execution breakpoint table.
// Request codes, controller states and the controller/datapath handshake structs.
`default_nettype none

package ebt_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned SlotW = 4;

  typedef enum logic [1:0] {
    REQ_CHECK  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;      // latch request, reset slot index
    logic read;      // issue table read at current index
    logic step;      // advance slot index
    logic hit;       // commit hit at current index
    logic miss;      // record no-hit result
    logic out_load;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic valid_req;  // latched request code is one of the known ones
    logic addr_zero;  // latched address is zero
    logic match;      // current slot satisfies the search
    logic last;       // current index is the highest slot
    logic out_busy;   // output register holds an untaken result
  } status_t;

endpackage

`default_nettype wire

>>> sv/execution_breakpoint_table.sv
// Top level of the execution breakpoint table: controller plus datapath.
// Depends on ebt_pkg, ebt_ctrl, ebt_dp (and ebt_ram below it).
//
// Holds SLOT_COUNT breakpoint addresses in a single-port-read RAM with one
// occupancy bit per slot, cleared by reset. Each request (check pc, insert,
// remove) is handled by a sequencer that visits the slots from the lowest up,
// each slot with a RAM read, then a compare, and stops at the first hit.
// One request is in flight at a time. A request is rejected up front when its
// address is zero or its code unknown; otherwise the slot walk runs through
// the RAM read port. The result sits in an output register, so it may wait
// for the consumer while the next request is taken; slot reports the low 4
// bits of the slot number and is zero when nothing was found.
`default_nettype none

module execution_breakpoint_table
  import ebt_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       req_type_i,
  input  wire logic [AddrW-1:0] address_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  success_o,
  output logic [SlotW-1:0]      slot_o,
  output logic                  stop_at_breakpoint_o
);

  cmd_t    cmd;
  status_t status;

  ebt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  ebt_dp #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .req_type_i          (req_type_i),
    .address_i           (address_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .success_o           (success_o),
    .slot_o              (slot_o),
    .stop_at_breakpoint_o(stop_at_breakpoint_o)
  );

endmodule

`default_nettype wire

>>> sv/ebt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ebt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/ebt_ctrl.sv
// Sequencer for the breakpoint table: walks the slots one at a time.
// Depends on ebt_pkg for states and command/status structs.
`default_nettype none

module ebt_ctrl
  import ebt_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        // unknown codes and address zero never hit anything
        if (!status_i.valid_req || status_i.addr_zero) begin
          cmd_o.miss = 1'b1;
          state_d    = ST_FINISH;
        end else begin
          cmd_o.read = 1'b1;
          state_d    = ST_CMP;
        end
      end
      ST_CMP: begin
        priority if (status_i.match) begin
          cmd_o.hit = 1'b1;
          state_d   = ST_FINISH;
        end else if (status_i.last) begin
          cmd_o.miss = 1'b1;
          state_d    = ST_FINISH;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/ebt_dp.sv
// Datapath: request latch, slot index, address RAM, occupancy bits, result
// and output registers. Depends on ebt_pkg and ebt_ram.
`default_nettype none

module ebt_dp
  import ebt_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [1:0]       req_type_i,
  input  wire logic [AddrW-1:0] address_i,
  input  wire cmd_t             cmd_i,
  output status_t               status_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  success_o,
  output logic [SlotW-1:0]      slot_o,
  output logic                  stop_at_breakpoint_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  logic [1:0]            req_q;
  logic [AddrW-1:0]      addr_q;
  logic [IdxW-1:0]       idx_q;
  logic [SLOT_COUNT-1:0] used_q;
  logic [AddrW-1:0]      rdata;
  logic                  res_hit_q;
  logic [IdxW-1:0]       res_idx_q;
  logic                  out_valid_q;
  req_e                  req;
  logic                  ram_we;

  assign req = req_e'(req_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      addr_q <= address_i;
    end
    if (cmd_i.hit) begin
      res_idx_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      used_q    <= '0;
      res_hit_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.hit) begin
        res_hit_q <= 1'b1;
        if (req == REQ_INSERT) begin
          used_q[idx_q] <= 1'b1;
        end else if (req == REQ_REMOVE) begin
          used_q[idx_q] <= 1'b0;
        end
      end else if (cmd_i.miss) begin
        res_hit_q <= 1'b0;
      end
    end
  end

  assign ram_we = cmd_i.hit && (req == REQ_INSERT);

  ebt_ram #(
    .Width(AddrW),
    .Depth(SLOT_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(addr_q),
    .re_i   (cmd_i.read),
    .raddr_i(idx_q),
    .rdata_o(rdata)
  );

  // Insert looks for a free slot; check and remove look for an occupied equal one.
  always_comb begin
    status_o.valid_req = 1'b0;
    status_o.match     = 1'b0;
    unique case (req)
      REQ_CHECK, REQ_REMOVE: begin
        status_o.valid_req = 1'b1;
        status_o.match     = used_q[idx_q] && (rdata == addr_q);
      end
      REQ_INSERT: begin
        status_o.valid_req = 1'b1;
        status_o.match     = !used_q[idx_q];
      end
      default: begin
        status_o.valid_req = 1'b0;
        status_o.match     = 1'b0;
      end
    endcase
    status_o.addr_zero = (addr_q == '0);
    status_o.last      = (idx_q == LastIdx);
    status_o.out_busy  = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      success_o            <= res_hit_q;
      slot_o               <= res_hit_q ? SlotW'(res_idx_q) : '0;
      stop_at_breakpoint_o <= res_hit_q && (req == REQ_CHECK);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
